// ===== hw/rtl/audio_level_bass_meter_macros.svh =====
// Assertion macros shared by the audio level and bass meter RTL.
`ifndef AUDIO_LEVEL_BASS_METER_MACROS_SVH
`define AUDIO_LEVEL_BASS_METER_MACROS_SVH

// Same-cycle implication, checked on i_clk and disabled while i_rst_n is low.
`define ALVBM_CHECK_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk and disabled while i_rst_n is low.
`define ALVBM_CHECK_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/alvbm_pkg.sv =====
// Shared types and constants of the audio level and bass meter.
package alvbm_pkg;

    // Default number of channel filter slots.
    localparam int MaxChannelsDef = 8;

    // Field and register widths.
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;
    localparam int RawW     = 32;
    localparam int ChanW    = 3;
    localparam int RmsW     = 16;
    localparam int CntCmpW  = 6;

    // Largest RMS value, 1.0 in Q1.15.
    localparam logic [RmsW-1:0] RmsMax = 16'h8000;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_DC_COEFF      = 3'd0,
        CFG_BASS_COEFF    = 3'd1,
        CFG_SAMPLE_BYTES  = 3'd2,
        CFG_CHANNEL_COUNT = 3'd3,
        CFG_LEVEL_ENABLE  = 3'd4,
        CFG_BASS_ENABLE   = 3'd5
    } t_cfg_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic load_work;
        logic mul_dc;
        logic upd_dc;
        logic mul_l1;
        logic upd_l1;
        logic mul_l2;
        logic upd_l2;
        logic sq_bass;
        logic acc_bass;
        logic div_start;
        logic sqrt_start;
        logic sel_bass;
        logic store_res;
        logic load_out;
        logic clear_sums;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_analyze;
        logic push_use;
        logic count_zero;
        logic div_done;
        logic sqrt_done;
    } t_status;

endpackage

// ===== hw/rtl/alvbm_div.sv =====
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module alvbm_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quotient
);

    logic [63:0] r_quo;
    logic [31:0] r_rem;
    logic [31:0] r_dvs;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic        q_bit;

    // One trial subtraction of the shifted remainder.
    always_comb begin
        rem_sh  = {r_rem, r_quo[63]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        q_bit   = (rem_sh >= {1'b0, r_dvs});
    end

    // Quotient bits shift in as dividend bits shift out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
            r_cnt  <= 7'd64;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_quo <= {r_quo[62:0], q_bit};
            r_rem <= q_bit ? rem_sub[31:0] : rem_sh[31:0];
            r_cnt <= r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== hw/rtl/alvbm_sqrt.sv =====
// Integer square root of a 64-bit word, one root bit per cycle.
module alvbm_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic [63:0] r_rad;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic [35:0] rem_sub;
    logic        r_bit;

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
        rem_sh  = {r_rem, r_rad[63:62]};
        trial   = {2'b00, r_root, 2'b01};
        rem_sub = rem_sh - trial;
        r_bit   = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= 6'd32;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[61:0], 2'b00};
            r_rem  <= r_bit ? rem_sub[33:0] : rem_sh[33:0];
            r_root <= {r_root[30:0], r_bit};
            r_cnt  <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== hw/rtl/alvbm_dpath.sv =====
// Datapath: configuration, sample conversion, filters, energy sums and RMS.
module alvbm_dpath #(
    parameter int MAX_CHANNELS = alvbm_pkg::MaxChannelsDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [alvbm_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [alvbm_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                          i_func,
    input  logic [alvbm_pkg::RawW-1:0]    i_raw_sample,
    input  logic [alvbm_pkg::ChanW-1:0]   i_channel,
    input  logic                          i_silent,
    input  alvbm_pkg::t_cmd               i_cmd,
    output alvbm_pkg::t_status            o_status,
    output logic [alvbm_pkg::RmsW-1:0]    o_level_rms,
    output logic [alvbm_pkg::RmsW-1:0]    o_bass_rms
);
    import alvbm_pkg::*;

    localparam int ChIdxW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int ChExtW = (ChIdxW > ChanW) ? ChIdxW : ChanW;

    // Configuration registers.
    logic [15:0] r_dc_coeff;
    logic [15:0] r_bass_coeff;
    logic [2:0]  r_sample_bytes;
    logic [3:0]  r_channel_count;
    logic        r_level_en;
    logic        r_bass_en;

    // Captured input word.
    logic             r_func;
    logic [RawW-1:0]  r_raw;
    logic [ChanW-1:0] r_ch;
    logic             r_silent;

    // Per-channel filter states.
    logic signed [31:0] r_dc_mem [MAX_CHANNELS];
    logic signed [31:0] r_l1_mem [MAX_CHANNELS];
    logic signed [31:0] r_l2_mem [MAX_CHANNELS];

    // Working registers.
    logic signed [15:0] r_x;
    logic signed [31:0] r_dc;
    logic signed [31:0] r_l1;
    logic signed [31:0] r_l2;
    logic signed [51:0] r_prod;
    logic [33:0]        r_sq;
    logic [63:0]        r_level_e;
    logic [63:0]        r_bass_e;
    logic [31:0]        r_count;
    logic [RmsW-1:0]    r_lvl_res;
    logic [RmsW-1:0]    r_bass_res;
    logic [RmsW-1:0]    r_out_level;
    logic [RmsW-1:0]    r_out_bass;

    logic [ChExtW-1:0]  ch_ext;
    logic [ChIdxW-1:0]  ch_idx;
    logic [CntCmpW-1:0] cc_lim;
    logic               in_use;
    logic signed [15:0] conv;
    logic signed [30:0] xx;
    logic signed [34:0] mul_a;
    logic signed [16:0] coeff_s;
    logic signed [51:0] n_prod;
    logic signed [16:0] sq_in;
    logic signed [33:0] sq_prod;
    logic signed [31:0] upd_target;
    logic signed [35:0] prod_sh;
    logic signed [36:0] upd_sum;
    logic signed [31:0] upd_val;
    logic               clear_all;
    logic [63:0]        div_dividend;
    logic               div_done;
    logic [63:0]        div_quo;
    logic               sqrt_done;
    logic [31:0]        sqrt_root;
    logic [RmsW-1:0]    root_sat;

    // Clamp a 37-bit signed sum into the 32-bit state range.
    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [31:0] res;
        if (!v[36] && (|v[35:31])) begin
            res = 32'sh7FFF_FFFF;
        end else if (v[36] && !(&v[35:31])) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Energy accumulation that sticks at the top.
    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [33:0] b);
        logic [64:0] s;
        s = 65'(a) + 65'(b);
        return s[64] ? '1 : s[63:0];
    endfunction

    // Channel index and use check.
    always_comb begin
        ch_ext = ChExtW'(r_ch);
        ch_idx = ch_ext[ChIdxW-1:0];
        cc_lim = (CntCmpW'(r_channel_count) > CntCmpW'(MAX_CHANNELS)) ?
                 CntCmpW'(MAX_CHANNELS) : CntCmpW'(r_channel_count);
        in_use = (CntCmpW'(r_ch) < cc_lim);
    end

    // PCM container to Q1.15; one byte is offset binary.
    always_comb begin
        case (r_sample_bytes) inside
            3'd0, 3'd1: conv = {~r_raw[7], r_raw[6:0], 8'h00};
            3'd2:       conv = r_raw[15:0];
            3'd3:       conv = r_raw[23:8];
            default:    conv = r_raw[31:16];
        endcase
    end

    // Shared filter multiplier operands.
    always_comb begin
        xx = {r_x, 15'd0};
        if (i_cmd.mul_dc) begin
            mul_a = 35'(xx) - 35'(r_dc);
        end else if (i_cmd.mul_l1) begin
            mul_a = 35'(xx) - 35'(r_dc) - 35'(r_l1);
        end else begin
            mul_a = 35'(r_l1) - 35'(r_l2);
        end
        coeff_s = {1'b0, (i_cmd.mul_dc ? r_dc_coeff : r_bass_coeff)};
        n_prod  = mul_a * coeff_s;
    end

    // Squarer for the level sample and the bass sample.
    always_comb begin
        sq_in   = i_cmd.sq_bass ? r_l2[31:15] : 17'(r_x);
        sq_prod = sq_in * sq_in;
    end

    // Filter state update: state plus the floored product, clamped.
    always_comb begin
        if (i_cmd.upd_dc) begin
            upd_target = r_dc;
        end else if (i_cmd.upd_l1) begin
            upd_target = r_l1;
        end else begin
            upd_target = r_l2;
        end
        prod_sh = r_prod[51:16];
        upd_sum = 37'(upd_target) + 37'(prod_sh);
        upd_val = sat32(upd_sum);
    end

    // A change of either enable starts the meter afresh.
    assign clear_all = i_cfg_we &&
        (((t_cfg_idx'(i_cfg_index) == CFG_LEVEL_ENABLE) && (i_cfg_data[0] != r_level_en)) ||
         ((t_cfg_idx'(i_cfg_index) == CFG_BASS_ENABLE) && (i_cfg_data[0] != r_bass_en)));

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc_coeff      <= 16'd186;
            r_bass_coeff    <= 16'd1842;
            r_sample_bytes  <= 3'd2;
            r_channel_count <= 4'd2;
            r_level_en      <= 1'b1;
            r_bass_en       <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DC_COEFF:      r_dc_coeff      <= i_cfg_data;
                CFG_BASS_COEFF:    r_bass_coeff    <= i_cfg_data;
                CFG_SAMPLE_BYTES:  r_sample_bytes  <= i_cfg_data[2:0];
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[3:0];
                CFG_LEVEL_ENABLE:  r_level_en      <= i_cfg_data[0];
                CFG_BASS_ENABLE:   r_bass_en       <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Input capture and working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func   <= i_func;
            r_raw    <= i_raw_sample;
            r_ch     <= i_channel;
            r_silent <= i_silent;
        end
        if (i_cmd.load_work) begin
            r_x  <= r_silent ? 16'sd0 : conv;
            r_dc <= r_dc_mem[ch_idx];
            r_l1 <= r_l1_mem[ch_idx];
            r_l2 <= r_l2_mem[ch_idx];
        end
        if (i_cmd.mul_dc || i_cmd.mul_l1 || i_cmd.mul_l2) begin
            r_prod <= n_prod;
        end
        if (i_cmd.mul_dc || i_cmd.sq_bass) begin
            r_sq <= sq_prod[33:0];
        end
        if (i_cmd.upd_dc) begin
            r_dc <= upd_val;
        end
        if (i_cmd.upd_l1) begin
            r_l1 <= upd_val;
        end
        if (i_cmd.upd_l2) begin
            r_l2 <= upd_val;
        end
    end

    // Filter state store, written back once all three stages are done and bass is enabled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear_all) begin
            for (int k = 0; k < MAX_CHANNELS; k++) begin
                r_dc_mem[k] <= '0;
                r_l1_mem[k] <= '0;
                r_l2_mem[k] <= '0;
            end
        end else if (i_cmd.upd_l2 && r_bass_en) begin
            r_dc_mem[ch_idx] <= r_dc;
            r_l1_mem[ch_idx] <= r_l1;
            r_l2_mem[ch_idx] <= upd_val;
        end
    end

    // Energy sums and sample count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear_all || i_cmd.clear_sums) begin
            r_level_e <= '0;
            r_bass_e  <= '0;
            r_count   <= '0;
        end else begin
            if (i_cmd.upd_dc && r_level_en) begin
                r_level_e <= sat_add(r_level_e, r_sq);
            end
            if (i_cmd.acc_bass) begin
                if (r_bass_en) begin
                    r_bass_e <= sat_add(r_bass_e, r_sq);
                end
                if (r_count != '1) begin
                    r_count <= r_count + 32'd1;
                end
            end
        end
    end

    // Mean and root units, shared by the level and bass results.
    assign div_dividend = i_cmd.sel_bass ? r_bass_e : r_level_e;

    alvbm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    alvbm_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sqrt_start),
        .i_radicand (div_quo),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    assign root_sat = (sqrt_root > 32'(RmsMax)) ? RmsMax : sqrt_root[RmsW-1:0];

    // Result registers and the output word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_res) begin
            if (i_cmd.sel_bass) begin
                r_bass_res <= root_sat;
            end else begin
                r_lvl_res <= root_sat;
            end
        end
        if (i_cmd.load_out) begin
            r_out_level <= (r_count == '0) ? '0 : r_lvl_res;
            r_out_bass  <= (r_count == '0) ? '0 : r_bass_res;
        end
    end

    assign o_level_rms = r_out_level;
    assign o_bass_rms  = r_out_bass;

    // Status towards the controller.
    always_comb begin
        o_status.is_analyze = r_func;
        o_status.push_use   = (r_level_en || r_bass_en) && in_use;
        o_status.count_zero = (r_count == '0);
        o_status.div_done   = div_done;
        o_status.sqrt_done  = sqrt_done;
    end

endmodule

// ===== hw/rtl/alvbm_ctrl.sv =====
// Controller: sequences the filter steps of a push and the RMS steps of an analyze.
`include "audio_level_bass_meter_macros.svh"

module alvbm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_out_stall,
    input  alvbm_pkg::t_status i_status,
    output logic               o_stall,
    output logic               o_valid,
    output alvbm_pkg::t_cmd    o_cmd
);
    import alvbm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_MUL_DC,
        S_UPD_DC,
        S_MUL_L1,
        S_UPD_L1,
        S_MUL_L2,
        S_UPD_L2,
        S_SQ_B,
        S_ACC_B,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SQ_GO,
        S_SQ_WAIT,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_sel_bass;
    logic   n_sel_bass;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // Next state and command decode.
    always_comb begin
        n_state    = r_state;
        n_sel_bass = r_sel_bass;
        o_cmd      = '0;
        o_cmd.sel_bass = r_sel_bass;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.load_work = 1'b1;
                if (i_status.is_analyze) begin
                    n_sel_bass = 1'b0;
                    n_state    = i_status.count_zero ? S_OUT : S_DIV_GO;
                end else begin
                    n_state = i_status.push_use ? S_MUL_DC : S_IDLE;
                end
            end
            S_MUL_DC: begin
                o_cmd.mul_dc = 1'b1;
                n_state      = S_UPD_DC;
            end
            S_UPD_DC: begin
                o_cmd.upd_dc = 1'b1;
                n_state      = S_MUL_L1;
            end
            S_MUL_L1: begin
                o_cmd.mul_l1 = 1'b1;
                n_state      = S_UPD_L1;
            end
            S_UPD_L1: begin
                o_cmd.upd_l1 = 1'b1;
                n_state      = S_MUL_L2;
            end
            S_MUL_L2: begin
                o_cmd.mul_l2 = 1'b1;
                n_state      = S_UPD_L2;
            end
            S_UPD_L2: begin
                o_cmd.upd_l2 = 1'b1;
                n_state      = S_SQ_B;
            end
            S_SQ_B: begin
                o_cmd.sq_bass = 1'b1;
                n_state       = S_ACC_B;
            end
            S_ACC_B: begin
                o_cmd.acc_bass = 1'b1;
                n_state        = S_IDLE;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_status.div_done) begin
                    n_state = S_SQ_GO;
                end
            end
            S_SQ_GO: begin
                o_cmd.sqrt_start = 1'b1;
                n_state          = S_SQ_WAIT;
            end
            S_SQ_WAIT: begin
                if (i_status.sqrt_done) begin
                    o_cmd.store_res = 1'b1;
                    if (r_sel_bass) begin
                        n_state = S_OUT;
                    end else begin
                        n_sel_bass = 1'b1;
                        n_state    = S_DIV_GO;
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.load_out   = 1'b1;
                    o_cmd.clear_sums = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, result selection and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel_bass  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sel_bass <= n_sel_bass;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    // A new result never overwrites one that is still waiting.
    `ALVBM_CHECK_IMP(a_load_when_free, o_cmd.load_out, !r_out_valid || !i_out_stall, "result overwritten while stalled")
    // An accepted word is always examined in the following cycle.
    `ALVBM_CHECK_NXT(a_accept_decides, i_valid && !o_stall, r_state == S_DECIDE, "accepted word not decoded")
    // The divider only runs with a non-zero sample count.
    `ALVBM_CHECK_IMP(a_div_nonzero, o_cmd.div_start, !i_status.count_zero, "division by a zero count")

endmodule

// ===== hw/rtl/audio_level_bass_meter.sv =====
// A push steps through decode, the DC filter, the two bass filter stages and the bass
// square and accumulate before the next word is taken. An analyze runs a division and
// a square root for the level, then for the bass, before its word is shown.
// A waiting result does not hold up pushes; a second analyze waits for it.
// Reset is synchronous and active low: registers return to defaults, states clear.
module audio_level_bass_meter #(
    parameter int MAX_CHANNELS = alvbm_pkg::MaxChannelsDef
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [alvbm_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [alvbm_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_func,
    input  logic [alvbm_pkg::RawW-1:0]     i_raw_sample,
    input  logic [alvbm_pkg::ChanW-1:0]    i_channel,
    input  logic                           i_silent,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [alvbm_pkg::RmsW-1:0]     o_level_rms,
    output logic [alvbm_pkg::RmsW-1:0]     o_bass_rms
);
    import alvbm_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer.
    alvbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_out_stall (i_stall),
        .i_status    (status),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_cmd       (cmd)
    );

    // Arithmetic and state.
    alvbm_dpath #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_func       (i_func),
        .i_raw_sample (i_raw_sample),
        .i_channel    (i_channel),
        .i_silent     (i_silent),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_level_rms  (o_level_rms),
        .o_bass_rms   (o_bass_rms)
    );

endmodule
